// ----- hw/rtl/ttt_pkg.sv -----
// shared types and constants of the transmit timestamp tracking table
`default_nettype none
package ttt_pkg;

    localparam int ID_BITS_DEF = 10;
    localparam int HANDLE_W    = 32;
    localparam int STAMP_W     = 64;
    localparam int COUNT_W     = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [31:0]          NONE_MARK     = 32'heeeeeeee;
    localparam logic [COUNT_W-1:0]   THRESHOLD_RST = 16'd256;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_OVERRUN  = 3'd1,
        ST_DONE     = 3'd2,
        ST_NO_ENTRY = 3'd3,
        ST_BAD_ID   = 3'd4,
        ST_DISABLED = 3'd5
    } status_t;

    typedef enum logic {
        REQ_ADD  = 1'b0,
        REQ_DONE = 1'b1
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE    = 1'b0,
        CFG_THRESHOLD = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ
    } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ttt_ifs.sv -----
// request and result channel interfaces
`default_nettype none
interface ttt_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] packet_handle;
    logic [31:0] entry_word;
    logic [31:0] hw_stamp;
    logic [63:0] free_clock;
    logic [63:0] controlled_clock;

    modport source (output valid, req_type, packet_handle, entry_word, hw_stamp,
                    free_clock, controlled_clock, input ready);
    modport sink (input valid, req_type, packet_handle, entry_word, hw_stamp,
                  free_clock, controlled_clock, output ready);
endinterface

interface ttt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] entry_id;
    logic [31:0] handle_out;
    logic [15:0] waiting_count;
    logic        alarm;
    logic [63:0] bridge_stamp;
    logic [63:0] controlled_stamp;

    modport source (output valid, status, entry_id, handle_out, waiting_count, alarm,
                    bridge_stamp, controlled_stamp, input ready);
    modport sink (input valid, status, entry_id, handle_out, waiting_count, alarm,
                  bridge_stamp, controlled_stamp, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tx_timestamp_tracking_table_core.sv -----
// top level of the transmit timestamp tracking table
// One request is taken, its table entry is read in the next cycle and the
// result is written to the output register while the entry is updated. The
// table memory has a registered read and requests do not overlap: a request
// stays in S_READ until the output register is free. Result beats wait in
// an output register, so a new request may be taken while the previous
// result is still unread; a result is only produced once that register is
// free. After reset the block walks the whole table once to clear the in-use
// flags (2^ID_BITS entries, 1024 at the default) and takes no request until
// then; configuration writes are taken at any time. Ids run from 1 to
// 2^ID_BITS - 1, id 0 is never issued.
`default_nettype none
module tx_timestamp_tracking_table_core import ttt_pkg::*; #(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    ttt_req_if.sink                    req,
    ttt_rsp_if.source                  rsp
);

    localparam int SLOTS = 2 ** ID_BITS;
    localparam int MEM_W = HANDLE_W + 1;

    state_t state_reg;
    state_t state_next;

    logic               enable_reg;
    logic [COUNT_W-1:0] threshold_reg;

    logic [ID_BITS-1:0] newest_reg;
    logic [ID_BITS-1:0] newest_next;
    logic [ID_BITS-1:0] last_done_reg;
    logic [ID_BITS-1:0] last_done_next;
    logic [ID_BITS-1:0] clr_cnt_reg;
    logic [ID_BITS-1:0] clr_cnt_next;

    // request held for the read cycle
    logic                req_type_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [15:0]         word_id_reg;
    logic                none_reg;
    logic                id_ok_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic [ID_BITS-1:0]  add_id;
    logic [ID_BITS-1:0]  acc_id;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             status_reg;
    status_t             status_next;
    logic [15:0]         entry_id_reg;
    logic [15:0]         entry_id_next;
    logic [HANDLE_W-1:0] handle_out_reg;
    logic [HANDLE_W-1:0] handle_out_next;
    logic [COUNT_W-1:0]  waiting_reg;
    logic [COUNT_W-1:0]  waiting_next;
    logic                alarm_reg;
    logic                alarm_next;
    logic [STAMP_W-1:0]  bstamp_reg;
    logic [STAMP_W-1:0]  bstamp_next;
    logic [STAMP_W-1:0]  cstamp_reg;
    logic [STAMP_W-1:0]  cstamp_next;

    logic               accept;
    logic               out_free;
    logic               advance;
    logic               mem_we;
    logic [ID_BITS-1:0] mem_waddr;
    logic [MEM_W-1:0]   mem_wdata;
    logic [MEM_W-1:0]   mem_rdata;
    logic               rd_used;
    logic [HANDLE_W-1:0] rd_handle;
    logic [STAMP_W-1:0] ext_stamp;
    logic [STAMP_W-1:0] ctl_stamp;
    logic [ID_BITS-1:0] diff;
    logic [ID_BITS-1:0] wait_ids;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign advance   = (state_reg == S_READ) && out_free;
    assign rd_used   = mem_rdata[MEM_W-1];
    assign rd_handle = mem_rdata[HANDLE_W-1:0];

    // next ring id, skipping zero
    always_comb
    begin
        add_id = newest_reg + ID_BITS'(1);
        if (add_id == '0)
        begin
            add_id = ID_BITS'(1);
        end
        acc_id = (req.req_type == REQ_ADD) ? add_id : req.entry_word[ID_BITS-1:0];
    end

    ttt_ram #(
        .WIDTH(MEM_W),
        .DEPTH(SLOTS)
    ) u_table (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (accept),
        .raddr(acc_id),
        .rdata(mem_rdata)
    );

    ttt_stamp u_stamp (
        .clk             (clk),
        .load            (accept),
        .hw_stamp        (req.hw_stamp),
        .free_clock      (req.free_clock),
        .controlled_clock(req.controlled_clock),
        .bridge_stamp    (ext_stamp),
        .controlled_stamp(ctl_stamp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ENABLE:    enable_reg    <= cfg_wdata[0];
                CFG_THRESHOLD: threshold_reg <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            newest_reg    <= ID_BITS'(1);
            last_done_reg <= ID_BITS'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            newest_reg    <= newest_next;
            last_done_reg <= last_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= req.req_type;
            handle_reg   <= req.packet_handle;
            word_id_reg  <= req.entry_word[15:0];
            none_reg     <= req.entry_word == NONE_MARK;
            id_ok_reg    <= (req.entry_word[15:0] != 16'd0)
                            && ((req.entry_word[15:0] >> ID_BITS) == 16'd0);
            id_reg       <= acc_id;
        end
        if (advance)
        begin
            status_reg     <= status_next;
            entry_id_reg   <= entry_id_next;
            handle_out_reg <= handle_out_next;
            waiting_reg    <= waiting_next;
            alarm_reg      <= alarm_next;
            bstamp_reg     <= bstamp_next;
            cstamp_reg     <= cstamp_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        newest_next     = newest_reg;
        last_done_next  = last_done_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        req.ready       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = id_reg;
        mem_wdata       = {1'b0, rd_handle};
        status_next     = ST_DISABLED;
        entry_id_next   = 16'd0;
        handle_out_next = '0;
        bstamp_next     = '0;
        cstamp_next     = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + ID_BITS'(1);
                if (clr_cnt_reg == ID_BITS'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (!enable_reg)
                begin
                    status_next = ST_DISABLED;
                end
                else if (req_type_reg == REQ_ADD)
                begin
                    newest_next   = id_reg;
                    entry_id_next = 16'(id_reg);
                    mem_we        = out_free;
                    mem_wdata     = {1'b1, handle_reg};
                    if (rd_used)
                    begin
                        status_next     = ST_OVERRUN;
                        handle_out_next = rd_handle;
                    end
                    else
                    begin
                        status_next = ST_ADDED;
                    end
                end
                else if (none_reg)
                begin
                    status_next = ST_BAD_ID;
                end
                else if (!id_ok_reg)
                begin
                    status_next   = ST_BAD_ID;
                    entry_id_next = word_id_reg;
                end
                else
                begin
                    last_done_next = id_reg;
                    entry_id_next  = word_id_reg;
                    if (rd_used)
                    begin
                        status_next     = ST_DONE;
                        handle_out_next = rd_handle;
                        bstamp_next     = ext_stamp;
                        cstamp_next     = ctl_stamp;
                        mem_we          = out_free;
                        mem_wdata       = {1'b0, rd_handle};
                    end
                    else
                    begin
                        status_next = ST_NO_ENTRY;
                    end
                end

                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    newest_next    = newest_reg;
                    last_done_next = last_done_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // ids waiting, modulo the count of nonzero ids
        diff     = newest_next - last_done_next;
        wait_ids = (newest_next >= last_done_next) ? diff : diff - ID_BITS'(1);
        if (enable_reg)
        begin
            waiting_next = COUNT_W'(wait_ids);
            alarm_next   = COUNT_W'(wait_ids) > threshold_reg;
        end
        else
        begin
            waiting_next = '0;
            alarm_next   = 1'b0;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = status_reg;
    assign rsp.entry_id         = entry_id_reg;
    assign rsp.handle_out       = handle_out_reg;
    assign rsp.waiting_count    = waiting_reg;
    assign rsp.alarm            = alarm_reg;
    assign rsp.bridge_stamp     = bstamp_reg;
    assign rsp.controlled_stamp = cstamp_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/ttt_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module ttt_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/ttt_stamp.sv -----
// timestamp extension to 64 bits and clock offset
`default_nettype none
module ttt_stamp import ttt_pkg::*; (
    input  wire logic               clk,
    input  wire logic               load,
    input  wire logic [31:0]        hw_stamp,
    input  wire logic [STAMP_W-1:0] free_clock,
    input  wire logic [STAMP_W-1:0] controlled_clock,
    output logic      [STAMP_W-1:0] bridge_stamp,
    output logic      [STAMP_W-1:0] controlled_stamp
);

    logic [STAMP_W-1:0] ext_reg;
    logic [STAMP_W-1:0] ext_next;
    logic [STAMP_W-1:0] offset_reg;
    logic [STAMP_W-1:0] offset_next;
    logic               wrap;
    logic [31:0]        high_word;

    // low word behind the stamp means one wrap since transmission
    always_comb
    begin
        wrap        = free_clock[31:0] < hw_stamp;
        high_word   = free_clock[63:32] - {31'd0, wrap};
        ext_next    = {high_word, hw_stamp};
        offset_next = controlled_clock - free_clock;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ext_reg    <= ext_next;
            offset_reg <= offset_next;
        end
    end

    assign bridge_stamp     = ext_reg;
    assign controlled_stamp = ext_reg + offset_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/ttt_checker.sv -----
// port-level checks of the tracking table core, bound to the top level
`default_nettype none
module ttt_checker import ttt_pkg::*; (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [2:0]  rsp_status,
    input wire logic [15:0] rsp_entry_id,
    input wire logic [31:0] rsp_handle_out,
    input wire logic [15:0] rsp_waiting_count,
    input wire logic        rsp_alarm
);

    // a result beat is held until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat dropped before it was taken");

    // the table read is registered, no back-to-back requests
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while the previous one is in flight");

    // an issued or completed id is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_ADDED || rsp_status == ST_OVERRUN
                      || rsp_status == ST_DONE || rsp_status == ST_NO_ENTRY)
        |-> rsp_entry_id != 16'd0)
        else $error("zero id reported");

    // a disabled answer carries nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_DISABLED
        |-> rsp_entry_id == 16'd0 && rsp_handle_out == 32'd0
            && rsp_waiting_count == 16'd0 && !rsp_alarm)
        else $error("disabled result carries data");

endmodule

bind tx_timestamp_tracking_table_core ttt_checker u_ttt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_entry_id     (rsp.entry_id),
    .rsp_handle_out   (rsp.handle_out),
    .rsp_waiting_count(rsp.waiting_count),
    .rsp_alarm        (rsp.alarm)
);
`default_nettype wire
